FILE: rtl/fmplf_pkg.sv
// ----------------------------------------------------------------------------
// First-match-per-line finder package
// Shared constants, types and the case-folding function for the finder.
// ----------------------------------------------------------------------------
`default_nettype none

package fmplf_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int PAT_BYTES   = 16;
    localparam int CELL_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LEN    = 3'd2,
        CFG_CASE_SENSITIVE = 3'd3,
        CFG_BASE_OFFSET    = 3'd4
    } t_cfg_idx;

    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_shift_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
        logic [7:0] r;
        r = b;
        if (!cs && (b >= UPPER_A) && (b <= UPPER_Z)) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/first_match_per_line_finder_core.sv
// ----------------------------------------------------------------------------
// First-match-per-line finder core
// Streams a text buffer a byte at a time and reports, for every line, the
// offset of the first occurrence of the configured pattern.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Word
//  in        input      i_in_valid/o_in_stall   i_data_byte, i_last_byte
//  out       output     o_out_valid/i_out_stall o_match_found,
//                                               o_match_position, o_end_of_buffer
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is taken every cycle while no output word is stalled; a result
// word appears in the cycle after the byte that causes it. The window
// compare runs in parallel across the row of cells, so the rate is set by
// nothing but the output register. Reset clears the window, the offset and
// the flags and loads the register defaults. A stalled output holds its word
// and stalls the input only while a word is waiting.
`default_nettype none

module first_match_per_line_finder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_match_found,
    output logic [31:0]      o_match_position,
    output logic             o_end_of_buffer,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [fmplf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import fmplf_pkg::*;

    logic [63:0] r_pattern_low;
    logic [63:0] r_pattern_high;
    logic [4:0]  r_pattern_len;
    logic        r_case_sens;
    logic [31:0] r_base_offset;

    t_pattern             pattern;
    logic [LEN_W-1:0]     act_len;
    t_shift_ctl           ctl;
    logic [PATTERN_MAX-1:0][7:0] win_bytes;
    logic [PATTERN_MAX-1:0]      hits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= 64'd0;
            r_pattern_high <= 64'd0;
            r_pattern_len  <= 5'd1;
            r_case_sens    <= 1'b1;
            r_base_offset  <= 32'd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pattern_low  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high <= i_cfg_data;
                CFG_PATTERN_LEN:    r_pattern_len  <= i_cfg_data[4:0];
                CFG_CASE_SENSITIVE: r_case_sens    <= i_cfg_data[0];
                CFG_BASE_OFFSET:    r_base_offset  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign pattern = {r_pattern_high, r_pattern_low};
    assign act_len = (r_pattern_len > 5'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                       : LEN_W'(r_pattern_len);

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_win
        logic [7:0] byte_in;
        if (k == 0) begin : g_head
            assign byte_in = i_data_byte;
        end else begin : g_body
            assign byte_in = win_bytes[k-1];
        end

        fmplf_cell u_win (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_cell_idx  (CELL_IDX_W'(k)),
            .i_len       (act_len),
            .i_case_sens (r_case_sens),
            .i_pattern   (pattern),
            .i_byte      (byte_in),
            .o_byte      (win_bytes[k]),
            .o_hit       (hits[k])
        );
    end

    fmplf_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_window_hit     (&hits),
        .i_len            (act_len),
        .i_base_offset    (r_base_offset),
        .o_ctl            (ctl),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_found    (o_match_found),
        .o_match_position (o_match_position),
        .o_end_of_buffer  (o_end_of_buffer)
    );

endmodule

`default_nettype wire

FILE: rtl/fmplf_cell.sv
// ----------------------------------------------------------------------------
// Finder window cell
// Holds one byte of the search window, passes it on at every shift and
// compares the byte entering it with the pattern byte that lines up there.
// ----------------------------------------------------------------------------
`default_nettype none

module fmplf_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fmplf_pkg::t_shift_ctl        i_ctl,
    input  wire logic [fmplf_pkg::CELL_IDX_W-1:0] i_cell_idx,
    input  wire logic [fmplf_pkg::LEN_W-1:0]  i_len,
    input  wire logic                         i_case_sens,
    input  wire fmplf_pkg::t_pattern          i_pattern,
    input  wire logic [7:0]                   i_byte,
    output logic [7:0]                        o_byte,
    output logic                              o_hit
);
    import fmplf_pkg::*;

    logic [7:0] r_byte;
    logic [4:0] pat_sel;
    logic       unused_pos;

    assign pat_sel    = 5'(i_len) - 5'd1 - 5'(i_cell_idx);
    assign unused_pos = (5'(i_cell_idx) >= 5'(i_len));

    assign o_hit = unused_pos ||
                   (fold_byte(i_byte, i_case_sens) ==
                    fold_byte(i_pattern[pat_sel[3:0]], i_case_sens));

    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= ZERO_BYTE;
        end else if (i_ctl.shift) begin
            r_byte <= i_ctl.clear ? ZERO_BYTE : i_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmplf_ctrl.sv
// ----------------------------------------------------------------------------
// Finder line control
// Keeps the byte offset and the line and stop flags, decides on a match and
// holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmplf_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_last_byte,
    input  wire logic                        i_window_hit,
    input  wire logic [fmplf_pkg::LEN_W-1:0] i_len,
    input  wire logic [31:0]                 i_base_offset,
    output fmplf_pkg::t_shift_ctl            o_ctl,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_match_found,
    output logic [31:0]                      o_match_position,
    output logic                             o_end_of_buffer
);
    import fmplf_pkg::*;

    logic        r_out_valid;
    logic        r_match_found;
    logic [31:0] r_match_position;
    logic        r_end_of_buffer;
    logic [31:0] r_byte_idx;
    logic        r_line_matched;
    logic        r_stopped;

    logic        accept;
    logic        stop_now;
    logic        filled;
    logic        found;
    logic [31:0] n_position;
    logic [31:0] n_byte_idx;
    logic        n_line_matched;
    logic        n_stopped;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign stop_now   = r_stopped | (i_data_byte == ZERO_BYTE);
    assign filled     = (i_len != '0) && (r_byte_idx >= (32'(i_len) - 32'd1));
    assign found      = ~stop_now & ~r_line_matched & i_window_hit & filled;
    assign n_position = r_byte_idx - 32'(i_len) + 32'd1 + i_base_offset;

    assign n_byte_idx     = i_last_byte ? 32'd0 : r_byte_idx + 32'd1;
    assign n_stopped      = i_last_byte ? 1'b0 : stop_now;
    assign n_line_matched = i_last_byte ? 1'b0 :
                            ((found | r_line_matched) & (i_data_byte != NEWLINE_BYTE));

    assign o_ctl.shift = accept;
    assign o_ctl.clear = i_last_byte;

    assign o_out_valid      = r_out_valid;
    assign o_match_found    = r_match_found;
    assign o_match_position = r_match_position;
    assign o_end_of_buffer  = r_end_of_buffer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_byte_idx     <= 32'd0;
            r_line_matched <= 1'b0;
            r_stopped      <= 1'b0;
        end else if (accept) begin
            r_out_valid    <= found | i_last_byte;
            r_byte_idx     <= n_byte_idx;
            r_line_matched <= n_line_matched;
            r_stopped      <= n_stopped;
        end else if (!i_out_stall) begin
            r_out_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_match_found    <= found;
            r_match_position <= found ? n_position : 32'd0;
            r_end_of_buffer  <= i_last_byte;
        end
    end

endmodule

`default_nettype wire
